/* rtl/white_patch_auto_white_balance_top_macros.svh */
// Assertion macros for the white-patch auto white balance block.
`ifndef WHITE_PATCH_AUTO_WHITE_BALANCE_TOP_MACROS_SVH
`define WHITE_PATCH_AUTO_WHITE_BALANCE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define WPB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WPB_ASSERT_IMP(label, clk, rst, ante, cons)
`define WPB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/wpawb_pkg.sv */
`default_nettype none
package wpawb_pkg;
  localparam int unsigned PixW = 15;
  localparam int unsigned GainW = 32;
  localparam logic [2:0] RegAuto = 3'd0;
  localparam logic [2:0] RegClip = 3'd1;
  localparam logic [2:0] RegGain0 = 3'd2;
  localparam logic [2:0] RegGain1 = 3'd3;
  localparam logic [2:0] RegGain2 = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an input item is accepted
    logic div_start; // load the divider for a channel
    logic div_step;  // one quotient bit
    logic div_store; // write the finished gain
    logic [1:0] chan;
  } wpawb_cmd_t;

  typedef struct packed {
    logic need_update; // the input item ends a frame with auto on
  } wpawb_sts_t;
endpackage
`default_nettype wire

/* rtl/wpawb_ctrl.sv */
`default_nettype none
module wpawb_ctrl #(
  parameter int unsigned QUOT_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic out_busy,
  input  wire wpawb_pkg::wpawb_sts_t sts,
  output wpawb_pkg::wpawb_cmd_t cmd
);
  import wpawb_pkg::*;
  localparam int unsigned CntW = $clog2(QUOT_BITS + 1);
  typedef enum logic [1:0] {S_RUN, S_LOAD, S_DIV, S_STORE} state_t;
  state_t state;
  logic [CntW-1:0] cnt;
  logic [1:0] chan;

  assign in_ready = (state == S_RUN) && !out_busy;
  always_comb begin
    cmd.take = in_valid && in_ready;
    cmd.div_start = (state == S_LOAD);
    cmd.div_step = (state == S_DIV);
    cmd.div_store = (state == S_STORE);
    cmd.chan = chan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      cnt <= '0;
      chan <= '0;
    end else begin
      unique case (state)
        S_RUN: if (cmd.take && sts.need_update) begin
          state <= S_LOAD;
          chan <= 2'd0;
        end
        S_LOAD: begin
          state <= S_DIV;
          cnt <= CntW'(QUOT_BITS);
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) state <= S_STORE;
        end
        S_STORE: begin
          if (chan == 2'd2) state <= S_RUN;
          else begin
            chan <= chan + 1'b1;
            state <= S_LOAD;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/wpawb_dp.sv */
`default_nettype none
module wpawb_dp #(
  parameter int unsigned PIXEL_BITS = 15,
  parameter int unsigned GAIN_FRACTION_BITS = 16,
  parameter int unsigned QUOT_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire wpawb_pkg::wpawb_cmd_t cmd,
  output wpawb_pkg::wpawb_sts_t sts,
  input  wire logic auto_enable,
  input  wire logic [wpawb_pkg::PixW-1:0] clip_threshold,
  input  wire logic [wpawb_pkg::GainW-1:0] manual_gain [3],
  input  wire logic [wpawb_pkg::PixW-1:0] ch_in [3],
  input  wire logic frame_end,
  input  wire logic out_ready,
  output logic out_valid,
  output logic [wpawb_pkg::PixW-1:0] ch_out [3],
  output logic frame_end_out
);
  import wpawb_pkg::*;
  localparam int unsigned ProdW = PIXEL_BITS + GainW;
  localparam int unsigned SumW = PIXEL_BITS + 2;
  localparam int unsigned MeanW = SumW + 17;
  localparam logic [16:0] Recip3 = 17'd43691;
  localparam logic [GainW-1:0] GainOne = GainW'(64'd1 << GAIN_FRACTION_BITS);
  localparam logic [PIXEL_BITS-1:0] PixMax = '1;

  logic [PIXEL_BITS-1:0] px [3];
  logic [SumW-1:0] sum;
  logic [MeanW-1:0] mprod;
  logic [PIXEL_BITS-1:0] mean;
  logic [PIXEL_BITS-1:0] bmean;
  logic [PIXEL_BITS-1:0] bpix [3];
  logic start_flag;
  logic [GainW-1:0] mgain [3];
  logic [GainW-1:0] g [3];
  logic [ProdW-1:0] prod [3];
  logic [ProdW-1:0] rnd [3];

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      px[i] = ch_in[i][PIXEL_BITS-1:0];
      g[i] = auto_enable ? mgain[i] : manual_gain[i];
      prod[i] = ProdW'(px[i]) * ProdW'(g[i]);
      rnd[i] = (prod[i] + (ProdW'(1) << (GAIN_FRACTION_BITS - 1))) >> GAIN_FRACTION_BITS;
      if (PixW'(px[i]) <= clip_threshold) sum = sum + SumW'(px[i]);
    end
    // Divide by three as a multiply by 2^17 / 3 rounded up; exact for every sum here.
    mprod = MeanW'(sum + 1'b1) * MeanW'(Recip3);
    mean = PIXEL_BITS'(mprod >> 17);
  end
  assign sts.need_update = frame_end && auto_enable;

  // Output register; the controller holds the input while it is full and the output is not ready.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.take) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.take) begin
      for (int i = 0; i < 3; i++)
        ch_out[i] <= (rnd[i] > ProdW'(PixMax)) ? PixW'(PixMax) : PixW'(rnd[i]);
      frame_end_out <= frame_end;
    end
  end

  // Brightest-pixel tracker.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_flag <= 1'b1;
      bmean <= '0;
      for (int i = 0; i < 3; i++) bpix[i] <= '0;
    end else if (cmd.take) begin
      if (start_flag || mean > bmean) begin
        bmean <= mean;
        for (int i = 0; i < 3; i++) bpix[i] <= px[i];
      end
      start_flag <= frame_end;
    end
  end

  // Restoring divider: one quotient bit a cycle.
  logic [PIXEL_BITS-1:0] top;
  logic [PIXEL_BITS-1:0] dvs;
  logic [QUOT_BITS-1:0] num;
  logic [PIXEL_BITS:0] rem;
  logic [PIXEL_BITS:0] rem_sh;
  logic [QUOT_BITS-1:0] quo;
  always_comb begin
    top = bpix[0];
    if (bpix[1] > top) top = bpix[1];
    if (bpix[2] > top) top = bpix[2];
    rem_sh = {rem[PIXEL_BITS-1:0], num[QUOT_BITS-1]};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) mgain[i] <= GainOne;
    end else if (cmd.div_store) begin
      if (dvs == '0) mgain[cmd.chan] <= GainOne;
      else if (quo[QUOT_BITS-1:GainW] != '0) mgain[cmd.chan] <= '1;
      else mgain[cmd.chan] <= quo[GainW-1:0];
    end
    if (cmd.div_start) begin
      dvs <= bpix[cmd.chan];
      num <= (QUOT_BITS'(top) << GAIN_FRACTION_BITS) +
             QUOT_BITS'(bpix[cmd.chan] >> 1);
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      num <= num << 1;
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[QUOT_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QUOT_BITS-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/white_patch_auto_white_balance_top.sv */
// White-patch auto white balance. Each item is one three-channel pixel; every
// channel is multiplied by its gain, rounded and saturated, and the result goes
// through an output register. An ordinary pixel does not itself hold the input.
// On a frame-end pixel with auto on, a bit-serial divider computes the three
// new gains, one quotient bit per cycle, and input is held until all three are
// stored; each gain takes QuotBits quotient bits, where QuotBits is the larger
// of PIXEL_BITS + GAIN_FRACTION_BITS + 1 and 33.
// A result that waits on the output also holds the input until it leaves.
// New gains apply from the next frame.
`default_nettype none
`include "white_patch_auto_white_balance_top_macros.svh"
module white_patch_auto_white_balance_top #(
  parameter int unsigned PIXEL_BITS = 15,
  parameter int unsigned GAIN_FRACTION_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [14:0] first_channel,
  input  wire logic [14:0] second_channel,
  input  wire logic [14:0] third_channel,
  input  wire logic frame_end,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [14:0] balanced_first,
  output logic [14:0] balanced_second,
  output logic [14:0] balanced_third,
  output logic frame_end_out
);
  import wpawb_pkg::*;
  // The quotient must be wider than a gain so that an overflow can be seen.
  localparam int unsigned QuotBits =
    (PIXEL_BITS + GAIN_FRACTION_BITS + 1 > GainW) ?
    PIXEL_BITS + GAIN_FRACTION_BITS + 1 : GainW + 1;
  localparam logic [GainW-1:0] GainOne = GainW'(64'd1 << GAIN_FRACTION_BITS);

  logic auto_enable;
  logic [PixW-1:0] clip_threshold;
  logic [GainW-1:0] manual_gain [3];
  logic [2:0] reg_idx;
  logic wr;
  wpawb_cmd_t cmd;
  wpawb_sts_t sts;
  logic [PixW-1:0] ch_in [3];
  logic [PixW-1:0] ch_out [3];

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  // Configuration registers; writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable <= 1'b0;
      clip_threshold <= PixW'(4000);
      for (int i = 0; i < 3; i++) manual_gain[i] <= GainOne;
    end else if (wr) begin
      unique case (reg_idx)
        RegAuto: auto_enable <= pwdata[0];
        RegClip: clip_threshold <= pwdata[PixW-1:0];
        RegGain0: manual_gain[0] <= pwdata;
        RegGain1: manual_gain[1] <= pwdata;
        RegGain2: manual_gain[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegAuto: prdata = {31'd0, auto_enable};
      RegClip: prdata = {17'd0, clip_threshold};
      RegGain0: prdata = manual_gain[0];
      RegGain1: prdata = manual_gain[1];
      RegGain2: prdata = manual_gain[2];
      default: prdata = '0;
    endcase
  end

  assign ch_in[0] = first_channel;
  assign ch_in[1] = second_channel;
  assign ch_in[2] = third_channel;
  assign balanced_first = ch_out[0];
  assign balanced_second = ch_out[1];
  assign balanced_third = ch_out[2];

  wpawb_ctrl #(.QUOT_BITS(QuotBits)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_valid && !out_ready), .sts(sts), .cmd(cmd)
  );

  wpawb_dp #(
    .PIXEL_BITS(PIXEL_BITS), .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS),
    .QUOT_BITS(QuotBits)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .auto_enable(auto_enable),
    .clip_threshold(clip_threshold), .manual_gain(manual_gain), .ch_in(ch_in),
    .frame_end(frame_end), .out_ready(out_ready), .out_valid(out_valid),
    .ch_out(ch_out), .frame_end_out(frame_end_out)
  );

  // A held result is never overwritten, and no item enters during a gain update.
  `WPB_ASSERT_IMP(a_no_overrun, clk, rst, out_valid && !out_ready, !in_ready)
  `WPB_ASSERT_IMP(a_no_take_div, clk, rst, cmd.div_step || cmd.div_store, !in_ready)
  `WPB_ASSERT_NEXT(a_update_starts, clk, rst, cmd.take && sts.need_update, cmd.div_start)
endmodule
`default_nettype wire

/* tb/tb_white_patch_auto_white_balance_top.sv */
`default_nettype none
module tb_white_patch_auto_white_balance_top;
  import wpawb_pkg::*;

  // Balance scoreboard: predicts every output pixel from the accepted input pixels and keeps
  // them in order until the block hands them back.
  class balance_scoreboard;
    bit [31:0] auto_on;
    bit [14:0] clip;
    bit [31:0] manual_gain [3];
    bit [14:0] bright_mean;
    bit [14:0] bright_px [3];
    bit starting;
    bit [31:0] measured_gain [3];
    bit [45:0] pending_pixels [$];
    int errors;

    function void clear();
      auto_on = 0;
      clip = 15'd4000;
      bright_mean = 0;
      starting = 1;
      for (int i = 0; i < 3; i++) begin
        manual_gain[i] = 32'h10000;
        bright_px[i] = 0;
        measured_gain[i] = 32'h10000;
      end
      pending_pixels.delete();
      errors = 0;
    endfunction

    function bit [14:0] scaled(bit [14:0] px, bit [31:0] g);
      bit [63:0] p;
      p = ({49'd0, px} * {32'd0, g} + 64'h8000) >> 16;
      return (p > 64'h7FFF) ? 15'h7FFF : p[14:0];
    endfunction

    function bit [31:0] ratio(bit [14:0] top, bit [14:0] c);
      bit [63:0] q;
      if (c == 0) begin
        return 32'h10000;
      end
      q = (({49'd0, top} << 16) + {50'd0, c[14:1]}) / {49'd0, c};
      return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    endfunction

    function void note_pixel(bit [14:0] a, bit [14:0] b, bit [14:0] c, bit fe);
      bit [14:0] px [3];
      bit [16:0] sum;
      bit [16:0] mean;
      bit [14:0] top;
      bit [45:0] r;
      px[0] = a;
      px[1] = b;
      px[2] = c;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        if (px[i] <= clip) begin
          sum += px[i];
        end
      end
      mean = (sum + 1) / 3;
      for (int i = 0; i < 3; i++) begin
        r[45 - 15 * i -: 15] = scaled(px[i], auto_on[0] ? measured_gain[i] : manual_gain[i]);
      end
      r[0] = fe;
      pending_pixels.insert(pending_pixels.size(), r);
      if (starting || mean > bright_mean) begin
        bright_mean = mean[14:0];
        for (int i = 0; i < 3; i++) begin
          bright_px[i] = px[i];
        end
      end
      starting = 0;
      if (fe) begin
        if (auto_on[0]) begin
          top = bright_px[0];
          if (bright_px[1] > top) top = bright_px[1];
          if (bright_px[2] > top) top = bright_px[2];
          for (int i = 0; i < 3; i++) begin
            measured_gain[i] = ratio(top, bright_px[i]);
          end
        end
        starting = 1;
      end
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_pixel(bit [14:0] a, bit [14:0] b, bit [14:0] c, bit fe);
      bit [45:0] w;
      if (pending_pixels.size() == 0) begin
        report("unexpected item", 1, 0);
        return;
      end
      w = pending_pixels.pop_front();
      if (a != w[45:31]) report("balanced_first", a, w[45:31]);
      if (b != w[30:16]) report("balanced_second", b, w[30:16]);
      if (c != w[15:1]) report("balanced_third", c, w[15:1]);
      if (fe != w[0]) report("frame_end_out", fe, w[0]);
    endtask
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [14:0] first_channel, second_channel, third_channel;
  logic frame_end;
  logic [14:0] balanced_first, balanced_second, balanced_third;
  logic frame_end_out;

  balance_scoreboard sb;
  int stall_mode;

  white_patch_auto_white_balance_top DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Output checking and receiver stalls. Each stall pattern lasts a while, so
  // there are stretches of full throughput as well as heavy back-pressure.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_pixel(balanced_first, balanced_second, balanced_third, frame_end_out);
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // One register write in the APB style: a setup cycle, then an access cycle.
  task write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      RegAuto: sb.auto_on = {31'd0, val[0]};
      RegClip: sb.clip = val[14:0];
      RegGain0: sb.manual_gain[0] = val;
      RegGain1: sb.manual_gain[1] = val;
      default: sb.manual_gain[2] = val;
    endcase
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Presents one pixel and holds it until the block takes it.
  task send_pixel(logic [14:0] a, logic [14:0] b, logic [14:0] c, logic fe);
    in_valid <= 1;
    first_channel <= a;
    second_channel <= b;
    third_channel <= c;
    frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(a, b, c, fe);
    @(negedge clk);
  endtask

  // Ends the current burst with a random gap, or keeps valid high.
  task maybe_gap();
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Channel values that favor the corners of the range and the clip edge.
  function logic [14:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 15'd0;
      1: return 15'h7FFF;
      2: return 15'(sb.clip + $urandom_range(0, 2) - 1);
      3: return 15'($urandom_range(0, 255));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function logic [31:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return 32'h10000;
      default: return $urandom();
    endcase
  endfunction

  // Waits for every prediction to drain, plus room for a gain update still
  // running in the divider after the last frame-end item left.
  task settle();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (sb.pending_pixels.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task random_frames(int n_items);
    int len, sent;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
      for (int i = 0; i < len; i++) begin
        send_pixel(pick_channel(), pick_channel(), pick_channel(),
                   (i == len - 1) || ($urandom_range(0, 40) == 0));
        maybe_gap();
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    stall_mode = 0;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_valid = 0;
    out_ready = 1;
    first_channel = 0;
    second_channel = 0;
    third_channel = 0;
    frame_end = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed part: reset gains, extremes, the clip edge, a frame whose
    // brightest pixel has a zero channel, and a mean tie between two pixels
    // that are not the brightest of their frame.
    send_pixel(15'h7FFF, 15'd0, 15'd4000, 1'b1);
    settle();
    write_reg(RegAuto, 32'd1);
    send_pixel(15'd4000, 15'd4001, 15'd1, 1'b0);
    send_pixel(15'd2000, 15'd1000, 15'd0, 1'b0);
    send_pixel(15'd1000, 15'd2000, 15'd0, 1'b1);
    send_pixel(15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0);
    send_pixel(15'd1, 15'd3999, 15'd2, 1'b1);
    send_pixel(15'd100, 15'd200, 15'd300, 1'b1);
    send_pixel(15'd5, 15'd5, 15'd5, 1'b1);
    settle();
    write_reg(RegClip, 32'd0);
    send_pixel(15'd0, 15'd0, 15'd0, 1'b1);
    send_pixel(15'd7, 15'd8, 15'd9, 1'b1);
    settle();
    write_reg(RegClip, 32'h7FFF);
    send_pixel(15'h7FFF, 15'h4000, 15'd1, 1'b1);
    send_pixel(15'h1234, 15'h2AAA, 15'h5555, 1'b1);
    settle();
    write_reg(RegAuto, 32'd0);
    write_reg(RegGain0, 32'hFFFFFFFF);
    write_reg(RegGain1, 32'd0);
    write_reg(RegGain2, 32'h00018000);
    send_pixel(15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0);
    send_pixel(15'd1, 15'd1, 15'd1, 1'b0);
    send_pixel(15'h5555, 15'h2AAA, 15'd3, 1'b1);
    settle();

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(RegAuto, {31'd0, 1'(ph % 3 != 0)});
      write_reg(RegClip, (ph % 4 == 1) ? 32'h7FFF : $urandom_range(0, 32767));
      write_reg(RegGain0, pick_gain());
      write_reg(RegGain1, pick_gain());
      write_reg(RegGain2, pick_gain());
      random_frames(155);
      settle();
    end
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("[white_patch_auto_white_balance_top] OK");
    end else begin
      $display("[white_patch_auto_white_balance_top] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("[white_patch_auto_white_balance_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/wpawb_pkg.sv
rtl/wpawb_ctrl.sv
rtl/wpawb_dp.sv
rtl/white_patch_auto_white_balance_top.sv
tb/tb_white_patch_auto_white_balance_top.sv
